// File: rtl/ppcp_pkg.sv
// Shared types and constants for the pen plot command parser.
// No dependencies; every other file refers to it by scoped names.
package ppcp_pkg;

  localparam int unsigned OUT_BITS = 31;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_D     = 8'h44;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_P     = 7'b0000010,
    PH_CMD   = 7'b0000100,
    PH_X     = 7'b0001000,
    PH_COMMA = 7'b0010000,
    PH_Y     = 7'b0100000,
    PH_BAD   = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PU   = 2'd1,
    CMD_PD   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic       eos;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } res_set_t;

endpackage

// File: rtl/ppcp_in_reg.sv
// Input register stage of the pen plot command parser.
// Depends on ppcp_pkg for the request type.
module ppcp_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  ppcp_pkg::in_item_t s_item,
  input  logic               go,
  output logic               valid,
  output ppcp_pkg::in_item_t item
);

  assign s_ready = !valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      valid <= 1'b1;
    end else if (go) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

// File: rtl/ppcp_parse.sv
// Token parser: phase, command, decimal accumulators, pen position and track flag.
// Depends on ppcp_pkg; produces up to two results per request.
module ppcp_parse #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  ppcp_pkg::in_item_t item,
  output ppcp_pkg::res_set_t res
);

  localparam int unsigned W = (COORD_BITS > ppcp_pkg::OUT_BITS) ? COORD_BITS
                                                                : ppcp_pkg::OUT_BITS;
  localparam logic [W+3:0] LIMIT = {{(W + 4 - COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

  ppcp_pkg::phase_t phase, phase_next;
  ppcp_pkg::cmd_t   cmd, cmd_next;
  logic [W-1:0]     first, first_next;
  logic [W-1:0]     second, second_next;
  logic [ppcp_pkg::OUT_BITS-1:0] pen_x, pen_x_next, pen_y, pen_y_next;
  logic             track_open, track_open_next;

  logic       upper, digit, kept;
  logic [3:0] d;
  logic [7:0] c;

  function automatic logic [W-1:0] acc_digit(input logic [W-1:0] a, input logic [3:0] dv);
    logic [W+3:0] wide;
    logic [W+3:0] sum;
    wide = {4'b0000, a};
    sum = (wide << 3) + (wide << 1) + (W + 4)'(dv);
    return (sum > LIMIT) ? LIMIT[W-1:0] : sum[W-1:0];
  endfunction

  assign c     = item.char_code;
  assign upper = (c >= ppcp_pkg::CH_A) && (c <= ppcp_pkg::CH_Z);
  assign digit = (c >= ppcp_pkg::CH_0) && (c <= ppcp_pkg::CH_9);
  assign kept  = upper || digit || (c == ppcp_pkg::CH_BANG) || (c == ppcp_pkg::CH_COMMA);
  assign d     = c[3:0];

  always_comb begin
    phase_next      = phase;
    cmd_next        = cmd;
    first_next      = first;
    second_next     = second;
    pen_x_next      = pen_x;
    pen_y_next      = pen_y;
    track_open_next = track_open;
    res             = '0;

    if (item.eos) begin
      if (track_open) begin
        res.n         = 2'd1;
        res.r0.kind   = ppcp_pkg::KIND_CLOSE;
        res.r0.last   = 1'b1;
      end
      phase_next      = ppcp_pkg::PH_START;
      cmd_next        = ppcp_pkg::CMD_NONE;
      first_next      = '0;
      second_next     = '0;
      pen_x_next      = '0;
      pen_y_next      = '0;
      track_open_next = 1'b0;
    end else if (c == ppcp_pkg::CH_SEMI) begin
      if ((phase == ppcp_pkg::PH_CMD || phase == ppcp_pkg::PH_Y) &&
          cmd == ppcp_pkg::CMD_PU) begin
        if (track_open) begin
          res.n       = 2'd1;
          res.r0.kind = ppcp_pkg::KIND_CLOSE;
          res.r0.last = 1'b1;
        end
        track_open_next = 1'b0;
        if (phase == ppcp_pkg::PH_Y) begin
          pen_x_next = first[ppcp_pkg::OUT_BITS-1:0];
          pen_y_next = second[ppcp_pkg::OUT_BITS-1:0];
        end
      end else if (phase == ppcp_pkg::PH_Y && cmd == ppcp_pkg::CMD_PD) begin
        if (track_open) begin
          res.n      = 2'd1;
          res.r0.x   = first[ppcp_pkg::OUT_BITS-1:0];
          res.r0.y   = second[ppcp_pkg::OUT_BITS-1:0];
          res.r0.last = 1'b1;
        end else begin
          res.n      = 2'd2;
          res.r0.x   = pen_x;
          res.r0.y   = pen_y;
          res.r1.x   = first[ppcp_pkg::OUT_BITS-1:0];
          res.r1.y   = second[ppcp_pkg::OUT_BITS-1:0];
          res.r1.last = 1'b1;
        end
        pen_x_next      = first[ppcp_pkg::OUT_BITS-1:0];
        pen_y_next      = second[ppcp_pkg::OUT_BITS-1:0];
        track_open_next = 1'b1;
      end
      phase_next  = ppcp_pkg::PH_START;
      cmd_next    = ppcp_pkg::CMD_NONE;
      first_next  = '0;
      second_next = '0;
    end else if (kept) begin
      case (phase)
        ppcp_pkg::PH_START: begin
          phase_next = (c == ppcp_pkg::CH_P) ? ppcp_pkg::PH_P : ppcp_pkg::PH_BAD;
        end
        ppcp_pkg::PH_P: begin
          if (c == ppcp_pkg::CH_U) begin
            cmd_next   = ppcp_pkg::CMD_PU;
            phase_next = ppcp_pkg::PH_CMD;
          end else if (c == ppcp_pkg::CH_D) begin
            cmd_next   = ppcp_pkg::CMD_PD;
            phase_next = ppcp_pkg::PH_CMD;
          end else begin
            phase_next = ppcp_pkg::PH_BAD;
          end
        end
        ppcp_pkg::PH_CMD: begin
          if (digit) begin
            first_next = W'(d);
            phase_next = ppcp_pkg::PH_X;
          end else begin
            phase_next = ppcp_pkg::PH_BAD;
          end
        end
        ppcp_pkg::PH_X: begin
          if (digit) begin
            first_next = acc_digit(first, d);
          end else if (c == ppcp_pkg::CH_COMMA) begin
            phase_next = ppcp_pkg::PH_COMMA;
          end else begin
            phase_next = ppcp_pkg::PH_BAD;
          end
        end
        ppcp_pkg::PH_COMMA: begin
          if (digit) begin
            second_next = W'(d);
            phase_next  = ppcp_pkg::PH_Y;
          end else begin
            phase_next = ppcp_pkg::PH_BAD;
          end
        end
        ppcp_pkg::PH_Y: begin
          if (digit) begin
            second_next = acc_digit(second, d);
          end else begin
            phase_next = ppcp_pkg::PH_BAD;
          end
        end
        default: begin
          phase_next = ppcp_pkg::PH_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ppcp_pkg::PH_START;
      cmd        <= ppcp_pkg::CMD_NONE;
      first      <= '0;
      second     <= '0;
      pen_x      <= '0;
      pen_y      <= '0;
      track_open <= 1'b0;
    end else if (go) begin
      phase      <= phase_next;
      cmd        <= cmd_next;
      first      <= first_next;
      second     <= second_next;
      pen_x      <= pen_x_next;
      pen_y      <= pen_y_next;
      track_open <= track_open_next;
    end
  end

endmodule

// File: rtl/ppcp_out_buf.sv
// Two-entry result register feeding the master side.
// Depends on ppcp_pkg for the result types.
module ppcp_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ppcp_pkg::res_set_t res,
  output logic               can_load,
  output logic               m_valid,
  input  logic               m_ready,
  output ppcp_pkg::result_t  head
);

  logic [1:0]        cnt;
  ppcp_pkg::result_t e0, e1;
  logic              pop;

  assign m_valid  = (cnt != 2'd0);
  assign pop      = m_valid && m_ready;
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && m_ready);
  assign head     = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e0 <= res.r0;
      e1 <= res.r1;
    end else if (pop) begin
      e0 <= e1;
    end
  end

endmodule

// File: rtl/pen_plot_command_parser.sv
// Top level of the pen plot command parser: input register, parser, result buffer.
// Depends on ppcp_pkg, ppcp_in_reg, ppcp_parse and ppcp_out_buf.
//
//   channel  | dir | tdata                          | tuser    | tlast
//   s_axis   | in  | [7:0] char_code                | -        | end_of_stream
//   m_axis   | out | [30:0] x, [61:31] y, [63:62] 0 | [0] kind | last
//
// Each request is parsed out of the input register into the result buffer.
// A request yielding one result sustains one request per cycle while m_tready is high;
// one with two results (pen-down opening a track) holds the input as the buffer drains.
// An input handshake reaches output valid via the input register and the result buffer.
// Reset (rst, synchronous) clears the token, pen position and track flag.
// Output stalls back up through the two-entry buffer into the input register.
module pen_plot_command_parser #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [30:0] x, [61:31] y, [63:62] zero
  output logic [0:0]  m_tuser,   // [0] kind
  output logic        m_tlast    // last
);

  ppcp_pkg::in_item_t s_item, item;
  ppcp_pkg::res_set_t res;
  ppcp_pkg::result_t  head;
  logic               in_valid, can_load, go;

  assign s_item.char_code = s_tdata;
  assign s_item.eos       = s_tlast;
  assign go               = in_valid && can_load;

  ppcp_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .go      (go),
    .valid   (in_valid),
    .item    (item)
  );

  ppcp_parse #(
    .COORD_BITS (COORD_BITS)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (item),
    .res  (res)
  );

  ppcp_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (go),
    .res      (res),
    .can_load (can_load),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .head     (head)
  );

  assign m_tdata    = {2'b00, head.y, head.x};
  assign m_tuser[0] = head.kind;
  assign m_tlast    = head.last;

`ifndef SYNTHESIS
  a_close_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == ppcp_pkg::KIND_CLOSE) |-> m_tlast)
    else $error("close marker without last");

  a_close_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == ppcp_pkg::KIND_CLOSE) |-> (m_tdata[61:0] == 62'd0))
    else $error("close marker with nonzero coordinates");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tuser[0] == ppcp_pkg::KIND_POINT))
    else $error("first of a result pair not followed by a point");
`endif

endmodule
